// ===== sv/ecd_pkg.sv =====
// shared constants, codes and types for the elevator call dispatcher
package ecd_pkg;

  // building size and cabin start floor
  localparam int FLOORS = 16;
  localparam int START  = 0;
  localparam int IDX_W  = (FLOORS > 2) ? $clog2(FLOORS) : 1;

  localparam logic [IDX_W-1:0] CABIN_RST =
    (START < FLOORS) ? IDX_W'(START) : IDX_W'(FLOORS - 1);
  localparam logic [IDX_W-1:0] TOP_FLOOR = IDX_W'(FLOORS - 1);

  // wait marks
  localparam logic [1:0] MARK_NONE = 2'd0;
  localparam logic [1:0] MARK_UP   = 2'd1;
  localparam logic [1:0] MARK_DOWN = 2'd2;
  localparam logic [1:0] MARK_BOTH = 2'd3;

  // controller modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_FOUND   = 2'd1;
  localparam logic [1:0] MODE_MOVING  = 2'd2;
  localparam logic [1:0] MODE_REACHED = 2'd3;

  // commands
  localparam logic [2:0] CMD_NONE = 3'd0;
  localparam logic [2:0] CMD_OPEN = 3'd1;
  localparam logic [2:0] CMD_PREP = 3'd2;
  localparam logic [2:0] CMD_CONT = 3'd3;
  localparam logic [2:0] CMD_STOP = 3'd4;

  // event codes
  localparam logic [1:0] OP_HALL  = 2'd0;
  localparam logic [1:0] OP_CABIN = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_READY = 2'd3;

  // two-bit signed directions
  localparam logic [1:0] DIR_IDLE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b11;

  // per-cell mark updates
  localparam logic [1:0] CW_MERGE  = 2'd0;
  localparam logic [1:0] CW_CLEAR  = 2'd1;
  localparam logic [1:0] CW_ARRIVE = 2'd2;

  typedef struct packed {
    logic             en;
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic [1:0]       mark;
  } cell_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] cabin;
    logic [1:0]       last_dir;
  } scan_ctx_t;

  typedef struct packed {
    logic             valid;
    logic             dir_found;
    logic [IDX_W-1:0] dir_floor;
    logic             near_found;
    logic [IDX_W-1:0] near_floor;
    logic [IDX_W-1:0] near_dist;
  } scan_pkt_t;

endpackage

// ===== sv/ecd_cell.sv =====
// one floor cell: holds the wait mark and folds it into the passing scan packet
module ecd_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic [ecd_pkg::IDX_W-1:0] cell_idx,
  input  ecd_pkg::cell_wr_t  wr,
  input  ecd_pkg::scan_ctx_t ctx,
  input  ecd_pkg::scan_pkt_t pkt_in,
  output ecd_pkg::scan_pkt_t pkt_out
);
  import ecd_pkg::*;

  logic [1:0]       mark;
  logic [1:0]       mark_next;
  logic [IDX_W-1:0] reach;
  logic             above;
  logic             below;
  logic             dir_hit;
  scan_pkt_t        pkt_next;

  // mark update when this floor is addressed
  always_comb begin
    mark_next = mark;
    if (wr.en && wr.idx == cell_idx) begin
      case (wr.op)
        CW_MERGE: begin
          if (mark == MARK_NONE) begin
            mark_next = wr.mark;
          end else if (mark != wr.mark) begin
            mark_next = MARK_BOTH;
          end
        end
        CW_CLEAR:  mark_next = MARK_NONE;
        CW_ARRIVE: mark_next = (mark == MARK_BOTH) ? wr.mark : MARK_NONE;
        default:   mark_next = mark;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= MARK_NONE;
    end else begin
      mark <= mark_next;
    end
  end

  // distance to the cabin and side of the cabin
  assign above = cell_idx > ctx.cabin;
  assign below = cell_idx < ctx.cabin;
  assign reach = above ? (cell_idx - ctx.cabin) : (ctx.cabin - cell_idx);

  // directional match: first floor ahead going up, last floor below going down
  always_comb begin
    dir_hit = 1'b0;
    case (ctx.last_dir)
      DIR_UP:   dir_hit = above && (mark == MARK_UP || mark == MARK_BOTH)
                          && !pkt_in.dir_found;
      DIR_DOWN: dir_hit = below && (mark == MARK_DOWN || mark == MARK_BOTH);
      default:  dir_hit = 1'b0;
    endcase
  end

  // fold this floor into the packet
  always_comb begin
    pkt_next = pkt_in;
    if (dir_hit) begin
      pkt_next.dir_found = 1'b1;
      pkt_next.dir_floor = cell_idx;
    end
    if (mark != MARK_NONE && (!pkt_in.near_found || reach < pkt_in.near_dist)) begin
      pkt_next.near_found = 1'b1;
      pkt_next.near_floor = cell_idx;
      pkt_next.near_dist  = reach;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.valid <= 1'b0;
    end else begin
      pkt_out <= pkt_next;
    end
  end

endmodule

// ===== sv/ecd_chain.sv =====
// row of floor cells; the scan packet walks one floor per cycle
module ecd_chain (
  input  logic               clk,
  input  logic               rst,
  input  ecd_pkg::cell_wr_t  wr,
  input  ecd_pkg::scan_ctx_t ctx,
  input  logic               launch,
  output ecd_pkg::scan_pkt_t result
);
  import ecd_pkg::*;

  scan_pkt_t launch_pkt;
  scan_pkt_t links [FLOORS];

  // empty packet entering floor 0
  always_comb begin
    launch_pkt       = '0;
    launch_pkt.valid = launch;
  end

  for (genvar g = 0; g < FLOORS; g++) begin : g_cell
    if (g == 0) begin : g_first
      ecd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_idx (IDX_W'(g)),
        .wr       (wr),
        .ctx      (ctx),
        .pkt_in   (launch_pkt),
        .pkt_out  (links[g])
      );
    end else begin : g_rest
      ecd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_idx (IDX_W'(g)),
        .wr       (wr),
        .ctx      (ctx),
        .pkt_in   (links[g-1]),
        .pkt_out  (links[g])
      );
    end
  end

  assign result = links[FLOORS-1];

endmodule

// ===== sv/elevator_call_dispatch_fsm_top.sv =====
// elevator call dispatcher: event sequencer over a row of floor cells
// path of an event: input capture in idle, apply, a scan of the cell row when a goal search runs,
//   finish, then the output register
// throughput: one event at a time; a search walks the cell row one floor per cycle
// the next event is taken while a finished result still waits at the output
// reset (rst, synchronous): all marks none, cabin at START clamped, no goal, mode idle
module elevator_call_dispatch_fsm_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [3:0]        floor,
  input  logic              call_dir,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        command,
  output logic [3:0]        current_floor,
  output logic [3:0]        target_floor,
  output logic              target_valid,
  output logic [1:0]        fsm_state,
  output logic signed [1:0] heading
);
  import ecd_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]       state, state_next;
  logic [1:0]       op_q;
  logic [3:0]       floor_q;
  logic             dir_q;
  logic [IDX_W-1:0] cabin, cabin_next;
  logic [IDX_W-1:0] goal, goal_next;
  logic             goal_ok, goal_ok_next;
  logic [1:0]       mode, mode_next;
  logic [1:0]       travel, travel_next;
  logic [1:0]       last_dir, last_dir_next;
  logic [2:0]       cmd, cmd_next;
  logic             is_rest, is_rest_next;
  logic             scan_go, scan_go_next;
  logic             out_free;

  cell_wr_t         wr;
  scan_ctx_t        ctx;
  scan_pkt_t        result;

  logic             floor_ok;
  logic [IDX_W-1:0] f_idx;
  logic [1:0]       call_mark;
  logic             at_rest;
  logic [IDX_W-1:0] step_floor;
  logic             t_found;
  logic [IDX_W-1:0] t_floor;

  ecd_chain u_chain (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .ctx    (ctx),
    .launch (scan_go),
    .result (result)
  );

  assign ctx.cabin    = cabin;
  assign ctx.last_dir = last_dir;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // decoded event fields
  assign floor_ok = (32'(floor_q) < FLOORS);
  assign f_idx    = IDX_W'(floor_q);
  assign at_rest  = (mode == MODE_IDLE) || (mode == MODE_REACHED);

  always_comb begin
    if (op_q == OP_HALL) begin
      call_mark = dir_q ? MARK_DOWN : MARK_UP;
    end else if (f_idx > cabin) begin
      call_mark = MARK_UP;
    end else if (f_idx < cabin) begin
      call_mark = MARK_DOWN;
    end else begin
      call_mark = MARK_NONE;
    end
  end

  // next cabin floor on a tick, held at the ends
  always_comb begin
    case (travel)
      DIR_UP:   step_floor = (cabin == TOP_FLOOR) ? cabin : cabin + 1'b1;
      DIR_DOWN: step_floor = (cabin == '0) ? cabin : cabin - 1'b1;
      default:  step_floor = cabin;
    endcase
  end

  // search result from the end of the row
  assign t_found = result.dir_found || result.near_found;
  assign t_floor = result.dir_found ? result.dir_floor : result.near_floor;

  // event sequencer
  always_comb begin
    state_next    = state;
    cabin_next    = cabin;
    goal_next     = goal;
    goal_ok_next  = goal_ok;
    mode_next     = mode;
    travel_next   = travel;
    last_dir_next = last_dir;
    cmd_next      = cmd;
    is_rest_next  = is_rest;
    scan_go_next  = 1'b0;
    wr            = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_APPLY;
        end
      end

      ST_APPLY: begin
        state_next = ST_FIN;
        cmd_next   = CMD_NONE;
        case (op_q)
          OP_HALL, OP_CABIN: begin
            if (floor_ok) begin
              wr.en  = 1'b1;
              wr.idx = f_idx;
              if (at_rest && f_idx == cabin) begin
                // call at the cabin floor opens the doors
                wr.op    = CW_CLEAR;
                cmd_next = CMD_OPEN;
              end else begin
                wr.op   = CW_MERGE;
                wr.mark = call_mark;
                if (mode == MODE_FOUND) begin
                  cmd_next = CMD_PREP;
                end else if (at_rest) begin
                  is_rest_next = 1'b1;
                  scan_go_next = 1'b1;
                  state_next   = ST_SCAN;
                end else begin
                  last_dir_next = travel;
                  is_rest_next  = 1'b0;
                  scan_go_next  = 1'b1;
                  state_next    = ST_SCAN;
                end
              end
            end
          end
          OP_TICK: begin
            if (mode == MODE_FOUND || mode == MODE_MOVING) begin
              mode_next  = MODE_MOVING;
              cabin_next = step_floor;
              if (goal_ok && step_floor == goal) begin
                mode_next = MODE_REACHED;
                wr.en     = 1'b1;
                wr.op     = CW_ARRIVE;
                wr.idx    = step_floor;
                wr.mark   = (travel == DIR_UP) ? MARK_DOWN : MARK_UP;
                cmd_next  = CMD_STOP;
              end else begin
                cmd_next = CMD_CONT;
              end
            end
          end
          default: begin
            if (at_rest) begin
              is_rest_next = 1'b1;
              scan_go_next = 1'b1;
              state_next   = ST_SCAN;
            end
          end
        endcase
      end

      ST_SCAN: begin
        if (result.valid) begin
          state_next = ST_FIN;
          cmd_next   = CMD_NONE;
          if (is_rest) begin
            if (t_found) begin
              goal_next     = t_floor;
              goal_ok_next  = 1'b1;
              last_dir_next = travel;
              mode_next     = MODE_FOUND;
              cmd_next      = CMD_PREP;
              if (t_floor > cabin) begin
                travel_next = DIR_UP;
              end else if (t_floor < cabin) begin
                travel_next = DIR_DOWN;
              end else begin
                travel_next = DIR_IDLE;
              end
            end else begin
              mode_next = MODE_IDLE;
            end
          end else if (t_found && !(goal_ok && t_floor == goal) && t_floor != cabin) begin
            // retarget while moving
            goal_next    = t_floor;
            goal_ok_next = 1'b1;
          end
        end
      end

      default: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cabin    <= CABIN_RST;
      goal     <= '0;
      goal_ok  <= 1'b0;
      mode     <= MODE_IDLE;
      travel   <= DIR_IDLE;
      last_dir <= DIR_IDLE;
      cmd      <= CMD_NONE;
      is_rest  <= 1'b0;
      scan_go  <= 1'b0;
    end else begin
      state    <= state_next;
      cabin    <= cabin_next;
      goal     <= goal_next;
      goal_ok  <= goal_ok_next;
      mode     <= mode_next;
      travel   <= travel_next;
      last_dir <= last_dir_next;
      cmd      <= cmd_next;
      is_rest  <= is_rest_next;
      scan_go  <= scan_go_next;
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q    <= op;
      floor_q <= floor;
      dir_q   <= call_dir;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      command       <= cmd;
      current_floor <= 4'(cabin);
      target_floor  <= goal_ok ? 4'(goal) : 4'd0;
      target_valid  <= goal_ok;
      fsm_state     <= mode;
      heading       <= travel;
    end
  end

endmodule

// ===== sv/ecd_checker.sv =====
// port-level checks on the elevator call dispatcher, bound to the top level
module ecd_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        command,
  input logic [3:0]        current_floor,
  input logic [3:0]        target_floor,
  input logic              target_valid,
  input logic [1:0]        fsm_state
);
  import ecd_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command) && $stable(current_floor))
    else $error("result beat changed while stalled");

  // no goal shows as floor zero
  a_no_goal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !target_valid |-> target_floor == 4'd0)
    else $error("target floor set without a goal");

  // stop leaves the controller at the goal
  a_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_STOP |-> fsm_state == MODE_REACHED
    && target_valid && target_floor == current_floor)
    else $error("stop without reaching the goal");

  // prepare always comes with a chosen goal
  a_prep: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_PREP |-> fsm_state == MODE_FOUND && target_valid)
    else $error("prepare without a goal");

  // continue only while moving
  a_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_CONT |-> fsm_state == MODE_MOVING)
    else $error("continue outside moving mode");

endmodule

bind elevator_call_dispatch_fsm_top ecd_checker u_ecd_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for the elevator call dispatcher with its own event predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ecd_pkg::*;

  localparam int RANDOM_EVENTS = 1780;
  localparam int SETTLE_CYCLES = 2 * FLOORS + 8;
  localparam int REPORT_CAP    = 100;
  localparam int PROBE_COUNT   = 22;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] flr;
    logic       cdir;
  } dispatch_event_t;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] cabin;
    logic [3:0] goal;
    logic       goal_set;
    logic [1:0] mode;
    logic [1:0] heading;
  } dispatch_result_t;

  typedef struct packed {
    dispatch_event_t  ev;
    logic             typed;
    dispatch_result_t want;
  } probe_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_LONG} stall_style_t;

  localparam dispatch_result_t NO_CHECK = '0;

  // directed walk from reset: extremes, every event, open at the cabin, ignored events,
  // both-mark arrival, goal at the cabin floor, goal kept while moving
  localparam probe_t PROBES [PROBE_COUNT] = '{
    '{'{OP_TICK,  4'd0,  1'b0}, 1'b1,
      '{CMD_NONE, CABIN_RST, 4'd0, 1'b0, MODE_IDLE, DIR_IDLE}},
    '{'{OP_READY, 4'd15, 1'b1}, 1'b1,
      '{CMD_NONE, CABIN_RST, 4'd0, 1'b0, MODE_IDLE, DIR_IDLE}},
    '{'{OP_CABIN, 4'd0,  1'b0}, 1'b1,
      '{CMD_OPEN, CABIN_RST, 4'd0, 1'b0, MODE_IDLE, DIR_IDLE}},
    '{'{OP_HALL,  4'd0,  1'b1}, 1'b1,
      '{CMD_OPEN, CABIN_RST, 4'd0, 1'b0, MODE_IDLE, DIR_IDLE}},
    '{'{OP_HALL,  4'd15, 1'b1}, 1'b0, NO_CHECK},
    '{'{OP_HALL,  4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_READY, 4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_TICK,  4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_CABIN, 4'd3,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_HALL,  4'd3,  1'b1}, 1'b0, NO_CHECK},
    '{'{OP_TICK,  4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_TICK,  4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_TICK,  4'd7,  1'b1}, 1'b0, NO_CHECK},
    '{'{OP_READY, 4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_TICK,  4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_HALL,  4'd5,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_HALL,  4'd1,  1'b1}, 1'b0, NO_CHECK},
    '{'{OP_TICK,  4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_TICK,  4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_CABIN, 4'd9,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_TICK,  4'd0,  1'b0}, 1'b0, NO_CHECK},
    '{'{OP_CABIN, 4'd7,  1'b0}, 1'b0, NO_CHECK}
  };

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        op;
  logic [3:0]        floor;
  logic              call_dir;
  logic              out_valid;
  logic              out_ready;
  logic [2:0]        command;
  logic [3:0]        current_floor;
  logic [3:0]        target_floor;
  logic              target_valid;
  logic [1:0]        fsm_state;
  logic signed [1:0] heading;

  elevator_call_dispatch_fsm_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .floor         (floor),
    .call_dir      (call_dir),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command       (command),
    .current_floor (current_floor),
    .target_floor  (target_floor),
    .target_valid  (target_valid),
    .fsm_state     (fsm_state),
    .heading       (heading)
  );

  // predictor state of the dispatcher
  logic [1:0] marks [FLOORS];
  int         cab;
  int         goal;
  bit         goal_ok;
  logic [1:0] ctrl_mode;
  int         trav;
  int         last_way;

  dispatch_result_t pending_results [$];

  int mismatch_count  = 0;
  int results_checked = 0;
  int events_sent     = 0;
  int busy_events     = 0;
  int ignored_events  = 0;
  int stops_predicted = 0;
  int clamp_ticks     = 0;
  int burst_left      = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("elevator_call_dispatch_fsm_top verification failed");
    $finish;
  end

  function automatic void reset_dispatch();
    foreach (marks[i]) marks[i] = MARK_NONE;
    cab       = int'(CABIN_RST);
    goal      = 0;
    goal_ok   = 1'b0;
    ctrl_mode = MODE_IDLE;
    trav      = 0;
    last_way  = 0;
  endfunction

  // nearest matching floor ahead in the last direction, else nearest marked floor
  function automatic int find_goal();
    int best;
    int best_d;
    int d;
    logic [1:0] rel;
    best   = -1;
    best_d = FLOORS + 1;
    if (last_way != 0) begin
      rel = (last_way > 0) ? MARK_UP : MARK_DOWN;
      for (int i = cab + last_way; i >= 0 && i < FLOORS; i += last_way)
        if (marks[i] == MARK_BOTH || marks[i] == rel) return i;
    end
    for (int i = 0; i < FLOORS; i++) begin
      if (marks[i] != MARK_NONE) begin
        d = (cab > i) ? cab - i : i - cab;
        if (d < best_d) begin
          best_d = d;
          best   = i;
        end
      end
    end
    return best;
  endfunction

  function automatic logic [2:0] start_trip();
    int t;
    t = find_goal();
    if (t < 0) begin
      ctrl_mode = MODE_IDLE;
      return CMD_NONE;
    end
    goal      = t;
    goal_ok   = 1'b1;
    last_way  = trav;
    trav      = (t == cab) ? 0 : ((t < cab) ? -1 : 1);
    ctrl_mode = MODE_FOUND;
    return CMD_PREP;
  endfunction

  function automatic logic [2:0] log_call(int f, logic [1:0] m);
    int t;
    if (marks[f] == MARK_NONE) marks[f] = m;
    else if (marks[f] != m) marks[f] = MARK_BOTH;
    if ((ctrl_mode == MODE_IDLE || ctrl_mode == MODE_REACHED) && f == cab) begin
      marks[f] = MARK_NONE;
      return CMD_OPEN;
    end
    if (ctrl_mode == MODE_FOUND) return CMD_PREP;
    if (ctrl_mode == MODE_IDLE || ctrl_mode == MODE_REACHED) return start_trip();
    // moving: retarget without turning around
    last_way = trav;
    t = find_goal();
    if (t >= 0 && !(goal_ok && t == goal) && t != cab) begin
      goal    = t;
      goal_ok = 1'b1;
    end
    return CMD_NONE;
  endfunction

  function automatic logic [2:0] pass_floor();
    int nf;
    if (ctrl_mode != MODE_FOUND && ctrl_mode != MODE_MOVING) return CMD_NONE;
    ctrl_mode = MODE_MOVING;
    nf = cab + trav;
    if (nf < 0) nf = 0;
    if (nf > FLOORS - 1) nf = FLOORS - 1;
    cab = nf;
    if (goal_ok && cab == goal) begin
      ctrl_mode = MODE_REACHED;
      if (marks[cab] == MARK_BOTH) marks[cab] = (trav > 0) ? MARK_DOWN : MARK_UP;
      else marks[cab] = MARK_NONE;
      return CMD_STOP;
    end
    return CMD_CONT;
  endfunction

  function automatic dispatch_result_t dispatch_event(dispatch_event_t c);
    dispatch_result_t r;
    logic [2:0] cmd;
    int fl;
    cmd = CMD_NONE;
    fl  = int'(c.flr);
    // calls above the top floor are dropped; unreachable while the field spans the building
    case (c.op)
      OP_HALL: begin
        if (fl < FLOORS) cmd = log_call(fl, c.cdir ? MARK_DOWN : MARK_UP);
      end
      OP_CABIN: begin
        if (fl < FLOORS)
          cmd = log_call(fl, (fl > cab) ? MARK_UP : ((fl < cab) ? MARK_DOWN : MARK_NONE));
      end
      OP_TICK: cmd = pass_floor();
      default: begin
        if (ctrl_mode == MODE_IDLE || ctrl_mode == MODE_REACHED) cmd = start_trip();
      end
    endcase
    r.command  = cmd;
    r.cabin    = 4'(cab);
    r.goal     = goal_ok ? 4'(goal) : 4'd0;
    r.goal_set = goal_ok;
    r.mode     = ctrl_mode;
    r.heading  = (trav > 0) ? DIR_UP : ((trav < 0) ? DIR_DOWN : DIR_IDLE);
    return r;
  endfunction

  // a goal behind a moving cabin can never be reached: the cabin runs into an end
  function automatic bit cabin_stranded();
    return ctrl_mode == MODE_MOVING && goal_ok && (goal - cab) * trav < 0;
  endfunction

  function automatic bit would_strand(dispatch_event_t c);
    logic [1:0] keep_marks [FLOORS];
    int keep_cab, keep_goal, keep_trav, keep_prev;
    bit keep_ok;
    logic [1:0] keep_mode;
    dispatch_result_t r;
    bit hit;
    if (ctrl_mode != MODE_MOVING || !(c.op == OP_HALL || c.op == OP_CABIN)) return 1'b0;
    keep_marks = marks;
    keep_cab   = cab;
    keep_goal  = goal;
    keep_ok    = goal_ok;
    keep_mode  = ctrl_mode;
    keep_trav  = trav;
    keep_prev  = last_way;
    r   = dispatch_event(c);
    hit = cabin_stranded();
    marks     = keep_marks;
    cab       = keep_cab;
    goal      = keep_goal;
    goal_ok   = keep_ok;
    ctrl_mode = keep_mode;
    trav      = keep_trav;
    last_way  = keep_prev;
    return hit;
  endfunction

  function automatic dispatch_event_t draw_call();
    dispatch_event_t c;
    c.op   = ($urandom_range(0, 1) != 0) ? OP_HALL : OP_CABIN;
    c.flr  = 4'($urandom_range(0, 15));
    c.cdir = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic dispatch_event_t plain_event(logic [1:0] code);
    dispatch_event_t c;
    c      = draw_call();
    c.op   = code;
    return c;
  endfunction

  // normal service: the event that fits the controller mode, a little noise,
  // and never a call that would strand the cabin
  function automatic dispatch_event_t draw_service();
    dispatch_event_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) c = plain_event(2'($urandom_range(0, 3)));
    else if (ctrl_mode == MODE_IDLE || ctrl_mode == MODE_REACHED) begin
      if (r < 45) c = plain_event(OP_READY);
      else if (r < 90) c = draw_call();
      else c = plain_event(OP_TICK);
    end else begin
      if (r < 65) c = plain_event(OP_TICK);
      else if (r < 95) c = draw_call();
      else c = plain_event(OP_READY);
    end
    for (int tries = 0; tries < 8 && would_strand(c); tries++) c = draw_call();
    if (would_strand(c)) c = plain_event(OP_TICK);
    return c;
  endfunction

  // closing stretch: steer the cabin past its goal and into an end of the shaft
  function automatic dispatch_event_t draw_runaway();
    dispatch_event_t c;
    if (cabin_stranded()) begin
      if ($urandom_range(0, 4) != 0) return plain_event(OP_TICK);
      return draw_call();
    end
    if (ctrl_mode == MODE_MOVING) begin
      for (int tries = 0; tries < 16; tries++) begin
        c = draw_call();
        if (would_strand(c)) return c;
      end
      return plain_event(OP_TICK);
    end
    if (ctrl_mode == MODE_FOUND) return plain_event(OP_TICK);
    if ($urandom_range(0, 1) != 0) return draw_call();
    return plain_event(OP_READY);
  endfunction

  // sender bursts with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // one event beat; called and returns at a falling edge
  task automatic send_event(dispatch_event_t c, bit typed, dispatch_result_t typed_res);
    dispatch_result_t r;
    bit quiet;
    pace();
    op       <= c.op;
    floor    <= c.flr;
    call_dir <= c.cdir;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    quiet = (c.op == OP_TICK && !(ctrl_mode == MODE_FOUND || ctrl_mode == MODE_MOVING)) ||
            (c.op == OP_READY && (ctrl_mode == MODE_FOUND || ctrl_mode == MODE_MOVING));
    if (c.op == OP_TICK && ctrl_mode == MODE_MOVING &&
        ((cab == 0 && trav < 0) || (cab == FLOORS - 1 && trav > 0)))
      clamp_ticks++;
    r = dispatch_event(c);
    pending_results.push_back(typed ? typed_res : r);
    events_sent++;
    if (quiet) ignored_events++;
    else busy_events++;
    if (r.command == CMD_STOP) stops_predicted++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // receiver stalls in a randomly chosen style that is drawn anew after each random span
  initial begin : receiver
    stall_style_t style;
    int span;
    int hold;
    bit lvl;
    out_ready = 1'b1;
    lvl  = 1'b1;
    hold = 0;
    forever begin
      style = stall_style_t'($urandom_range(0, 3));
      span  = $urandom_range(40, 400);
      repeat (span) begin
        @(negedge clk);
        case (style)
          STALL_NONE:  out_ready <= 1'b1;
          STALL_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          STALL_HALF:  out_ready <= 1'($urandom_range(0, 1));
          default: begin
            if (hold == 0) begin
              lvl  = !lvl;
              hold = lvl ? $urandom_range(1, 6) : $urandom_range(4, 24);
            end
            hold--;
            out_ready <= lvl;
          end
        endcase
      end
    end
  end

  function automatic void check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // result beats against the oldest expectation
  always @(posedge clk) begin : result_check
    dispatch_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: result beat with nothing expected, expected none, actual command %0d",
                   $time, command);
      end else begin
        want = pending_results.pop_front();
        check_field("command", {1'b0, want.command}, {1'b0, command});
        check_field("current_floor", want.cabin, current_floor);
        check_field("target_floor", want.goal, target_floor);
        check_field("target_valid", {3'b000, want.goal_set}, {3'b000, target_valid});
        check_field("fsm_state", {2'b00, want.mode}, {2'b00, fsm_state});
        check_field("heading", {2'b00, want.heading}, {2'b00, heading});
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int start_busy;
    int runaway;
    bit mid_drained;
    rst      = 1'b1;
    in_valid = 1'b0;
    op       = OP_HALL;
    floor    = 4'd0;
    call_dir = 1'b0;
    reset_dispatch();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed walk
    for (int i = 0; i < PROBE_COUNT; i++)
      send_event(PROBES[i].ev, PROBES[i].typed, PROBES[i].want);
    drain();

    // random service traffic, with one full drain halfway
    start_busy  = busy_events;
    mid_drained = 1'b0;
    while (busy_events - start_busy < RANDOM_EVENTS) begin
      if (!mid_drained && busy_events - start_busy >= RANDOM_EVENTS / 2) begin
        drain();
        mid_drained = 1'b1;
      end
      send_event(draw_service(), 1'b0, NO_CHECK);
    end

    // end of the shaft: the cabin is left with a goal behind it and pins at an end
    runaway = 0;
    while (clamp_ticks < 4 && runaway < 400) begin
      send_event(draw_runaway(), 1'b0, NO_CHECK);
      runaway++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("covered %0d events (%0d ignored by the controller), %0d results checked, %0d stops",
             events_sent, ignored_events, results_checked, stops_predicted);
    $display("cabin pinned at an end of the shaft for %0d floor ticks", clamp_ticks);
    if (mismatch_count == 0) begin
      $display("elevator_call_dispatch_fsm_top verification clean");
    end else begin
      $display("elevator_call_dispatch_fsm_top verification failed");
    end
    $finish;
  end

endmodule
